// ===== rtl/cnps_pkg.sv =====
// shared types, constants and helper functions of the cpio newc stream parser
// no dependencies; imported by cnps_core and referenced by the top level
`default_nettype none

package cnps_pkg;

   localparam int unsigned HEADER_BYTES       = 110;
   localparam int unsigned ENTRY_BITS_DEFAULT = 16;
   localparam int unsigned HEX_DIGITS         = 8;
   localparam int unsigned MODE_AT            = 14;
   localparam int unsigned FSIZE_AT           = 54;
   localparam int unsigned NSIZE_AT           = 94;
   localparam int unsigned TRAILER_LAST       = 10;
   localparam int unsigned TYPE_SHIFT         = 12;

   typedef enum logic [2:0] {
      REG_HEADER   = 3'd0,
      REG_NAME     = 3'd1,
      REG_NAME_PAD = 3'd2,
      REG_DATA     = 3'd3,
      REG_DATA_PAD = 3'd4,
      REG_DONE     = 3'd5
   } region_type;

   // expected name bytes of the closing entry, nul included
   function automatic logic [7:0] trailer_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h54; // T
         4'd1:    ch = 8'h52; // R
         4'd2:    ch = 8'h41; // A
         4'd3:    ch = 8'h49; // I
         4'd4:    ch = 8'h4C; // L
         4'd5:    ch = 8'h45; // E
         4'd6:    ch = 8'h52; // R
         4'd7:    ch = 8'h21; // !
         4'd8:    ch = 8'h21;
         4'd9:    ch = 8'h21;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // digits map to c-'0', everything else to c-'A'+10, wrapping at 32 bits
   function automatic logic [31:0] hex_value(input logic [7:0] c);
      logic [31:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 32'(c) - 32'd48;
      end else begin
         v = 32'(c) - 32'd55;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cpio_newc_stream_parser.sv =====
// Streaming parser for cpio new-ASCII archives. One archive byte goes in per
// word and exactly one tagged word comes out for it, in order: header, name,
// name pad, data, data pad, or after-trailer once the TRAILER!!! entry ends.
// The block sustains one byte per clock while rsp_ready does not stall it;
// each byte passes through the input register, then the result register,
// before its result word is valid. Mode, filesize and namesize are
// decoded on the fly and reported with every word.
// depends on cnps_pkg, cnps_in_reg, cnps_core
`default_nettype none

module cpio_newc_stream_parser #(
   parameter int unsigned ENTRY_BITS = cnps_pkg::ENTRY_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_archive_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_byte_out,
   output logic [2:0]       rsp_region,
   output logic [31:0]      rsp_region_offset,
   output logic             rsp_region_last,
   output logic [15:0]      rsp_entry_number,
   output logic [31:0]      rsp_data_length,
   output logic [31:0]      rsp_name_length,
   output logic [19:0]      rsp_file_type,
   output logic             rsp_trailer_seen
);

   logic       stg_valid;
   logic       stg_ready;
   logic [7:0] stg_byte;

   cnps_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_archive_byte (req_archive_byte),
      .out_valid        (stg_valid),
      .out_ready        (stg_ready),
      .out_byte         (stg_byte)
   );

   cnps_core #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (stg_valid),
      .in_ready          (stg_ready),
      .in_byte           (stg_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_region        (rsp_region),
      .rsp_region_offset (rsp_region_offset),
      .rsp_region_last   (rsp_region_last),
      .rsp_entry_number  (rsp_entry_number),
      .rsp_data_length   (rsp_data_length),
      .rsp_name_length   (rsp_name_length),
      .rsp_file_type     (rsp_file_type),
      .rsp_trailer_seen  (rsp_trailer_seen)
   );

endmodule

`default_nettype wire

// ===== rtl/cnps_in_reg.sv =====
// input register stage: holds one archive word until the core takes it
// no package dependencies
`default_nettype none

module cnps_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_archive_byte,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_ready) begin
         valid_in = req_valid;
         byte_in  = req_archive_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cnps_core.sv =====
// region tracking, header field decode and trailer match with the result register
// depends on cnps_pkg
`default_nettype none

module cnps_core #(
   parameter int unsigned ENTRY_BITS = cnps_pkg::ENTRY_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [7:0]  in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_byte_out,
   output logic [2:0]       rsp_region,
   output logic [31:0]      rsp_region_offset,
   output logic             rsp_region_last,
   output logic [15:0]      rsp_entry_number,
   output logic [31:0]      rsp_data_length,
   output logic [31:0]      rsp_name_length,
   output logic [19:0]      rsp_file_type,
   output logic             rsp_trailer_seen
);
   import cnps_pkg::*;

   region_type            region_ff, region_in;
   logic [31:0]           pos_ff, pos_in;
   logic [31:0]           dsize_ff, dsize_in;
   logic [31:0]           nsize_ff, nsize_in;
   logic [31:0]           mode_ff, mode_in;
   logic                  match_ff, match_in;
   logic                  found_ff, found_in;
   logic [ENTRY_BITS-1:0] entry_ff, entry_in;

   logic        ovalid_ff, ovalid_in;
   logic [7:0]  obyte_ff;
   logic [2:0]  oregion_ff;
   logic [31:0] ooff_ff;
   logic        olast_ff;
   logic [15:0] oentry_ff;
   logic [31:0] odsize_ff, onsize_ff;
   logic [19:0] otype_ff;
   logic        ofound_ff;

   logic        take;
   logic [31:0] region_len;
   logic [1:0]  name_pad, data_pad;
   logic [3:0]  nonempty;
   logic        last;
   logic [31:0] entry_wide;

   assign in_ready   = !ovalid_ff || rsp_ready;
   assign take       = in_valid && in_ready;
   assign entry_wide = 32'(entry_ff);

   // header plus name is padded to 4; 110 leaves a remainder of 2
   assign name_pad = 2'(2'd0 - 2'(HEADER_BYTES) - nsize_ff[1:0]);
   assign data_pad = 2'(2'd0 - dsize_ff[1:0]);
   assign nonempty = {data_pad != 2'd0, dsize_ff != 32'd0, name_pad != 2'd0, nsize_ff != 32'd0};

   always_comb begin
      unique case (region_ff)
         REG_HEADER:   region_len = 32'(HEADER_BYTES);
         REG_NAME:     region_len = nsize_ff;
         REG_NAME_PAD: region_len = 32'(name_pad);
         REG_DATA:     region_len = dsize_ff;
         REG_DATA_PAD: region_len = 32'(data_pad);
         default:      region_len = 32'd0;
      endcase
   end

   // next state of the parse
   always_comb begin
      region_in = region_ff;
      pos_in    = pos_ff;
      dsize_in  = dsize_ff;
      nsize_in  = nsize_ff;
      mode_in   = mode_ff;
      match_in  = match_ff;
      found_in  = found_ff;
      entry_in  = entry_ff;
      last      = 1'b0;

      if (region_ff == REG_DONE) begin
         if (pos_ff != '1) begin
            pos_in = pos_ff + 32'd1;
         end
      end else begin
         if (region_ff == REG_HEADER) begin
            if (pos_ff == 32'd0) begin
               match_in = 1'b1;
               found_in = 1'b0;
            end
            if (pos_ff >= 32'(MODE_AT) && pos_ff < 32'(MODE_AT + HEX_DIGITS)) begin
               mode_in = ((pos_ff == 32'(MODE_AT)) ? 32'd0 : {mode_ff[27:0], 4'd0})
                         + hex_value(in_byte);
            end else if (pos_ff >= 32'(FSIZE_AT) && pos_ff < 32'(FSIZE_AT + HEX_DIGITS)) begin
               dsize_in = ((pos_ff == 32'(FSIZE_AT)) ? 32'd0 : {dsize_ff[27:0], 4'd0})
                          + hex_value(in_byte);
            end else if (pos_ff >= 32'(NSIZE_AT) && pos_ff < 32'(NSIZE_AT + HEX_DIGITS)) begin
               nsize_in = ((pos_ff == 32'(NSIZE_AT)) ? 32'd0 : {nsize_ff[27:0], 4'd0})
                          + hex_value(in_byte);
            end
         end else if (region_ff == REG_NAME) begin
            if (pos_ff <= 32'(TRAILER_LAST) && match_ff) begin
               if (in_byte != trailer_char(pos_ff[3:0])) begin
                  match_in = 1'b0;
               end else if (pos_ff == 32'(TRAILER_LAST)) begin
                  found_in = 1'b1;
               end
            end
         end

         last = (pos_ff == region_len - 32'd1);
         if (last) begin
            pos_in = 32'd0;
            // skip empty regions; sizes only change inside the header
            priority if (region_ff < REG_NAME && nonempty[0]) begin
               region_in = REG_NAME;
            end else if (region_ff < REG_NAME_PAD && nonempty[1]) begin
               region_in = REG_NAME_PAD;
            end else if (region_ff < REG_DATA && nonempty[2]) begin
               region_in = REG_DATA;
            end else if (region_ff < REG_DATA_PAD && nonempty[3]) begin
               region_in = REG_DATA_PAD;
            end else if (found_in) begin
               region_in = REG_DONE;
            end else begin
               region_in = REG_HEADER;
               if (entry_ff != '1) begin
                  entry_in = entry_ff + ENTRY_BITS'(1);
               end
            end
         end else begin
            pos_in = pos_ff + 32'd1;
         end
      end
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      if (take) begin
         ovalid_in = 1'b1;
      end else if (rsp_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= REG_HEADER;
         pos_ff    <= 32'd0;
         dsize_ff  <= 32'd0;
         nsize_ff  <= 32'd0;
         mode_ff   <= 32'd0;
         match_ff  <= 1'b1;
         found_ff  <= 1'b0;
         entry_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
         if (take) begin
            region_ff <= region_in;
            pos_ff    <= pos_in;
            dsize_ff  <= dsize_in;
            nsize_ff  <= nsize_in;
            mode_ff   <= mode_in;
            match_ff  <= match_in;
            found_ff  <= found_in;
            entry_ff  <= entry_in;
         end
      end
   end

   // result word: position fields from before the word, sizes from after
   always_ff @(posedge clock) begin
      if (take) begin
         obyte_ff   <= in_byte;
         oregion_ff <= region_ff;
         ooff_ff    <= pos_ff;
         olast_ff   <= last;
         oentry_ff  <= entry_wide[15:0];
         odsize_ff  <= dsize_in;
         onsize_ff  <= nsize_in;
         otype_ff   <= mode_in[31:TYPE_SHIFT];
         ofound_ff  <= found_in;
      end
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_byte_out      = obyte_ff;
   assign rsp_region        = oregion_ff;
   assign rsp_region_offset = ooff_ff;
   assign rsp_region_last   = olast_ff;
   assign rsp_entry_number  = oentry_ff;
   assign rsp_data_length   = odsize_ff;
   assign rsp_name_length   = onsize_ff;
   assign rsp_file_type     = otype_ff;
   assign rsp_trailer_seen  = ofound_ff;

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      region_ff == REG_DONE |=> region_ff == REG_DONE)
      else $error("left the after-trailer region");

   a_header_bound: assert property (@(posedge clock) disable iff (reset)
      region_ff == REG_HEADER |-> pos_ff < 32'(HEADER_BYTES))
      else $error("header position out of range");

   a_done_no_last: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && oregion_ff == REG_DONE |-> !olast_ff && ofound_ff)
      else $error("after-trailer word flagged last or without trailer");

   a_pad_short: assert property (@(posedge clock) disable iff (reset)
      region_ff == REG_NAME_PAD || region_ff == REG_DATA_PAD |-> pos_ff < 32'd3)
      else $error("padding longer than three bytes");

endmodule

`default_nettype wire
